// ===== hw/rtl/tree_ancestor_distance_query_macros.svh =====
// Assertion macros for the checks in the top-level design file.
`ifndef TREE_ANCESTOR_DISTANCE_QUERY_MACROS_SVH
`define TREE_ANCESTOR_DISTANCE_QUERY_MACROS_SVH

// Same-cycle implication.
`define TADQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TADQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tadq_pkg.sv =====
package tadq_pkg;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 10;
   localparam int DIST_W  = 11;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BUILD_RD,
      S_BUILD_MID,
      S_BUILD_WR,
      S_QRY_DA,
      S_QRY_DB,
      S_QRY_CMP,
      S_LIFT,
      S_LIFT_WAIT,
      S_CLIMB_X,
      S_CLIMB_Y,
      S_CLIMB_CHK,
      S_DEP_L,
      S_DIST,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } entry_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [DIST_W-1:0] distance;
      logic              status;
   } result_type;

   localparam entry_type  ENTRY_NONE = '{valid: 1'b0, node: '0};
   localparam result_type RES_ACK    = '{ancestor: '0, distance: '0, status: 1'b0};
   localparam result_type RES_FAIL   = '{ancestor: '0, distance: '0, status: 1'b1};

endpackage

// ===== hw/rtl/tadq_ram.sv =====
module tadq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tadq_ctrl.sv =====
module tadq_ctrl #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_type,
   input  logic [tadq_pkg::NODE_W-1:0]           req_node_a,
   input  logic [tadq_pkg::NODE_W-1:0]           req_node_b,
   input  logic [tadq_pkg::NODE_W-1:0]           req_parent_node,
   input  logic                                  req_has_parent,
   input  logic [tadq_pkg::DEPTH_W-1:0]          req_node_depth,
   output logic                                  res_valid,
   output tadq_pkg::result_type                  res,
   input  logic                                  res_ready,
   output logic                                  tab_wr_en,
   output logic [$clog2(LEVELS+1)+$clog2(NODES)-1:0] tab_wr_addr,
   output tadq_pkg::entry_type                   tab_wr_data,
   output logic                                  tab_rd_en,
   output logic [$clog2(LEVELS+1)+$clog2(NODES)-1:0] tab_rd_addr,
   input  tadq_pkg::entry_type                   tab_rd_data,
   output logic                                  dep_wr_en,
   output logic [$clog2(NODES)-1:0]              dep_wr_addr,
   output logic [tadq_pkg::DEPTH_W-1:0]          dep_wr_data,
   output logic                                  dep_rd_en,
   output logic [$clog2(NODES)-1:0]              dep_rd_addr,
   input  logic [tadq_pkg::DEPTH_W-1:0]          dep_rd_data
);

   localparam int NW = $clog2(NODES);
   localparam int LW = $clog2(LEVELS + 1);
   localparam int XW = NW + tadq_pkg::NODE_W;

   tadq_pkg::state_type  state_ff, state_in;
   logic [LW-1:0]        lv_ff, lv_in;
   logic [NW-1:0]        nd_ff, nd_in;
   logic [tadq_pkg::NODE_W-1:0] a_ff, a_in, b_ff, b_in, hi_ff, hi_in, lo_ff, lo_in;
   logic [tadq_pkg::DEPTH_W-1:0] da_ff, da_in, db_ff, db_in, diff_ff, diff_in;
   tadq_pkg::entry_type  px_ff, px_in;
   logic                 fin_ff, fin_in;
   tadq_pkg::result_type res_ff, res_in;

   logic                 accept;
   logic                 a_ok, b_ok, par_ok;
   logic [LW-1:0]        lv_m1;
   logic                 cmp_ge;
   logic [tadq_pkg::DEPTH_W-1:0] diff_w;
   logic [tadq_pkg::DIST_W:0]    sum_w, twice_w, dist_w;

   function automatic logic [NW-1:0] node_idx(input logic [tadq_pkg::NODE_W-1:0] n);
      logic [XW-1:0] w;
      w = XW'(n);
      return w[NW-1:0];
   endfunction

   assign req_ready = (state_ff == tadq_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign a_ok      = 32'(req_node_a) < 32'(NODES);
   assign b_ok      = 32'(req_node_b) < 32'(NODES);
   assign par_ok    = 32'(req_parent_node) < 32'(NODES);
   assign lv_m1     = lv_ff - LW'(1);
   assign cmp_ge    = da_ff >= dep_rd_data;
   assign diff_w    = cmp_ge ? da_ff - dep_rd_data : dep_rd_data - da_ff;
   assign sum_w     = (tadq_pkg::DIST_W + 1)'(da_ff) + (tadq_pkg::DIST_W + 1)'(db_ff);
   assign twice_w   = {1'b0, dep_rd_data, 1'b0};
   assign dist_w    = sum_w - twice_w;
   assign res_valid = (state_ff == tadq_pkg::S_DONE);
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tadq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff   <= lv_in;
      nd_ff   <= nd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      diff_ff <= diff_in;
      px_ff   <= px_in;
      fin_ff  <= fin_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      lv_in       = lv_ff;
      nd_in       = nd_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      da_in       = da_ff;
      db_in       = db_ff;
      diff_in     = diff_ff;
      px_in       = px_ff;
      fin_in      = fin_ff;
      res_in      = res_ff;
      tab_wr_en   = 1'b0;
      tab_wr_addr = {lv_ff, nd_ff};
      tab_wr_data = tadq_pkg::ENTRY_NONE;
      tab_rd_en   = 1'b0;
      tab_rd_addr = {lv_ff, node_idx(hi_ff)};
      dep_wr_en   = 1'b0;
      dep_wr_addr = node_idx(req_node_a);
      dep_wr_data = req_node_depth;
      dep_rd_en   = 1'b0;
      dep_rd_addr = node_idx(a_ff);

      case (state_ff)
         tadq_pkg::S_IDLE: begin
            if (accept) begin
               res_in   = tadq_pkg::RES_ACK;
               state_in = tadq_pkg::S_DONE;
               case (req_type)
                  tadq_pkg::OP_LOAD: begin
                     if (a_ok) begin
                        tab_wr_en        = 1'b1;
                        tab_wr_addr      = {LW'(0), node_idx(req_node_a)};
                        tab_wr_data.valid = req_has_parent && par_ok;
                        tab_wr_data.node = (req_has_parent && par_ok) ? req_parent_node : '0;
                        dep_wr_en        = 1'b1;
                     end
                  end
                  tadq_pkg::OP_BUILD: begin
                     lv_in    = LW'(1);
                     nd_in    = '0;
                     state_in = tadq_pkg::S_BUILD_RD;
                  end
                  tadq_pkg::OP_QUERY: begin
                     a_in = req_node_a;
                     b_in = req_node_b;
                     if (a_ok && b_ok) begin
                        state_in = tadq_pkg::S_QRY_DA;
                     end else begin
                        res_in = tadq_pkg::RES_FAIL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         tadq_pkg::S_BUILD_RD: begin
            tab_rd_en   = 1'b1;
            tab_rd_addr = {lv_m1, nd_ff};
            state_in    = tadq_pkg::S_BUILD_MID;
         end

         tadq_pkg::S_BUILD_MID: begin
            if (tab_rd_data.valid) begin
               tab_rd_en   = 1'b1;
               tab_rd_addr = {lv_m1, node_idx(tab_rd_data.node)};
               state_in    = tadq_pkg::S_BUILD_WR;
            end else begin
               tab_wr_en = 1'b1;
               state_in  = tadq_pkg::S_BUILD_RD;
            end
         end

         tadq_pkg::S_BUILD_WR: begin
            tab_wr_en   = 1'b1;
            tab_wr_data = tab_rd_data;
            state_in    = tadq_pkg::S_BUILD_RD;
         end

         tadq_pkg::S_QRY_DA: begin
            dep_rd_en = 1'b1;
            state_in  = tadq_pkg::S_QRY_DB;
         end

         tadq_pkg::S_QRY_DB: begin
            da_in       = dep_rd_data;
            dep_rd_en   = 1'b1;
            dep_rd_addr = node_idx(b_ff);
            state_in    = tadq_pkg::S_QRY_CMP;
         end

         tadq_pkg::S_QRY_CMP: begin
            db_in   = dep_rd_data;
            hi_in   = cmp_ge ? a_ff : b_ff;
            lo_in   = cmp_ge ? b_ff : a_ff;
            diff_in = diff_w;
            lv_in   = '0;
            if ((11'(diff_w) >> (LEVELS + 1)) != 11'd0) begin
               res_in   = tadq_pkg::RES_FAIL;
               state_in = tadq_pkg::S_DONE;
            end else begin
               state_in = tadq_pkg::S_LIFT;
            end
         end

         tadq_pkg::S_LIFT: begin
            if (diff_ff == '0) begin
               fin_in = 1'b0;
               lv_in  = LW'(LEVELS);
               if (hi_ff == lo_ff) begin
                  state_in = tadq_pkg::S_DEP_L;
               end else begin
                  state_in = tadq_pkg::S_CLIMB_X;
               end
            end else if (diff_ff[0]) begin
               tab_rd_en = 1'b1;
               state_in  = tadq_pkg::S_LIFT_WAIT;
            end else begin
               diff_in = diff_ff >> 1;
               lv_in   = lv_ff + 1'b1;
            end
         end

         tadq_pkg::S_LIFT_WAIT: begin
            if (!tab_rd_data.valid) begin
               res_in   = tadq_pkg::RES_FAIL;
               state_in = tadq_pkg::S_DONE;
            end else begin
               hi_in    = tab_rd_data.node;
               diff_in  = diff_ff >> 1;
               lv_in    = lv_ff + 1'b1;
               state_in = tadq_pkg::S_LIFT;
            end
         end

         tadq_pkg::S_CLIMB_X: begin
            tab_rd_en = 1'b1;
            state_in  = tadq_pkg::S_CLIMB_Y;
         end

         tadq_pkg::S_CLIMB_Y: begin
            px_in       = tab_rd_data;
            tab_rd_en   = 1'b1;
            tab_rd_addr = {lv_ff, node_idx(lo_ff)};
            state_in    = tadq_pkg::S_CLIMB_CHK;
         end

         tadq_pkg::S_CLIMB_CHK: begin
            if (fin_ff) begin
               if (!px_ff.valid || (px_ff != tab_rd_data)) begin
                  res_in   = tadq_pkg::RES_FAIL;
                  state_in = tadq_pkg::S_DONE;
               end else begin
                  hi_in    = px_ff.node;
                  state_in = tadq_pkg::S_DEP_L;
               end
            end else begin
               if (px_ff.valid && tab_rd_data.valid && (px_ff != tab_rd_data)) begin
                  hi_in = px_ff.node;
                  lo_in = tab_rd_data.node;
               end
               if (lv_ff == '0) begin
                  fin_in = 1'b1;
               end else begin
                  lv_in = lv_m1;
               end
               state_in = tadq_pkg::S_CLIMB_X;
            end
         end

         tadq_pkg::S_DEP_L: begin
            dep_rd_en   = 1'b1;
            dep_rd_addr = node_idx(hi_ff);
            state_in    = tadq_pkg::S_DIST;
         end

         tadq_pkg::S_DIST: begin
            res_in.ancestor = hi_ff;
            res_in.distance = (sum_w < twice_w) ? '0 : dist_w[tadq_pkg::DIST_W-1:0];
            res_in.status   = 1'b0;
            state_in        = tadq_pkg::S_DONE;
         end

         tadq_pkg::S_DONE: begin
            if (res_ready) begin
               state_in = tadq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = tadq_pkg::S_IDLE;
         end
      endcase

      // Build advances to the next node once the current entry is written.
      if (tab_wr_en && (state_ff != tadq_pkg::S_IDLE)) begin
         if (nd_ff == NW'(NODES - 1)) begin
            nd_in = '0;
            if (lv_ff == LW'(LEVELS)) begin
               res_in   = tadq_pkg::RES_ACK;
               state_in = tadq_pkg::S_DONE;
            end else begin
               lv_in = lv_ff + 1'b1;
            end
         end else begin
            nd_in = nd_ff + 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/tree_ancestor_distance_query.sv =====
// Binary-lifting lowest common ancestor engine. A load transaction writes one node's parent
// and depth; a build transaction fills ancestor levels 1 to LEVELS by doubling, reading
// each node's lower-level entry and then either writing an empty entry when that ancestor
// is absent or reading the ancestor's own lower-level entry and writing it; a query
// transaction reads both depths, lifts the deeper node by the set bits of the depth gap,
// climbs both nodes from level LEVELS down to 0, reads the ancestor's depth and forms the
// distance; the climb is skipped when the lifted node equals the other one, and a query
// that fails on the way ends early. Every lift, climb and build step goes through the single
// read port of the ancestor table memory in turn. One transaction is worked on at a time,
// and the next is taken while a finished response still waits in the output register. The
// memories have no reset: every node a build or query touches must be loaded first, and a
// build must follow the loads before any query.
`include "tree_ancestor_distance_query_macros.svh"

module tree_ancestor_distance_query #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [tadq_pkg::NODE_W-1:0]   req_node_a,
   input  logic [tadq_pkg::NODE_W-1:0]   req_node_b,
   input  logic [tadq_pkg::NODE_W-1:0]   req_parent_node,
   input  logic                          req_has_parent,
   input  logic [tadq_pkg::DEPTH_W-1:0]  req_node_depth,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tadq_pkg::NODE_W-1:0]   rsp_ancestor,
   output logic [tadq_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_status
);

   localparam int NW        = $clog2(NODES);
   localparam int LW        = $clog2(LEVELS + 1);
   localparam int TAW       = LW + NW;
   localparam int TAB_DEPTH = (LEVELS + 1) * (2 ** NW);

   logic                          res_valid, res_ready;
   tadq_pkg::result_type          res;
   logic                          tab_wr_en, tab_rd_en;
   logic [TAW-1:0]                tab_wr_addr, tab_rd_addr;
   tadq_pkg::entry_type           tab_wr_data, tab_rd_data;
   logic                          dep_wr_en, dep_rd_en;
   logic [NW-1:0]                 dep_wr_addr, dep_rd_addr;
   logic [tadq_pkg::DEPTH_W-1:0]  dep_wr_data, dep_rd_data;

   logic                          rsp_valid_ff, rsp_valid_in;
   tadq_pkg::result_type          rsp_res_ff, rsp_res_in;

   tadq_ctrl #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_node (req_parent_node),
      .req_has_parent  (req_has_parent),
      .req_node_depth  (req_node_depth),
      .res_valid       (res_valid),
      .res             (res),
      .res_ready       (res_ready),
      .tab_wr_en       (tab_wr_en),
      .tab_wr_addr     (tab_wr_addr),
      .tab_wr_data     (tab_wr_data),
      .tab_rd_en       (tab_rd_en),
      .tab_rd_addr     (tab_rd_addr),
      .tab_rd_data     (tab_rd_data),
      .dep_wr_en       (dep_wr_en),
      .dep_wr_addr     (dep_wr_addr),
      .dep_wr_data     (dep_wr_data),
      .dep_rd_en       (dep_rd_en),
      .dep_rd_addr     (dep_rd_addr),
      .dep_rd_data     (dep_rd_data)
   );

   tadq_ram #(
      .WIDTH ($bits(tadq_pkg::entry_type)),
      .DEPTH (TAB_DEPTH)
   ) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   tadq_ram #(
      .WIDTH (tadq_pkg::DEPTH_W),
      .DEPTH (NODES)
   ) u_dep_ram (
      .clock   (clock),
      .wr_en   (dep_wr_en),
      .wr_addr (dep_wr_addr),
      .wr_data (dep_wr_data),
      .rd_en   (dep_rd_en),
      .rd_addr (dep_rd_addr),
      .rd_data (dep_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_res_ff.ancestor;
   assign rsp_distance = rsp_res_ff.distance;
   assign rsp_status   = rsp_res_ff.status;

   `TADQ_ASSERT_IMPL(a_idle_no_result, clock, reset, req_ready, !res_valid,
      "Controller offers a result while taking a new transaction.")

   `TADQ_ASSERT_IMPL(a_tab_no_overlap, clock, reset, tab_wr_en && tab_rd_en,
      tab_wr_addr != tab_rd_addr, "Ancestor table read and write hit the same entry.")

   `TADQ_ASSERT_NEXT(a_result_taken, clock, reset, res_valid && res_ready,
      rsp_valid && (rsp_status == $past(res.status)),
      "Handed result did not reach the output register.")

   `TADQ_ASSERT_IMPL(a_rsp_from_ctrl, clock, reset, $rose(rsp_valid), $past(res_valid),
      "Response appeared without a result from the controller.")

endmodule

// ===== tb/sv/lca_checker.sv =====
`timescale 1ns / 1ps

module lca_checker #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic [tadq_pkg::NODE_W-1:0]  req_node_a,
   input  logic [tadq_pkg::NODE_W-1:0]  req_node_b,
   input  logic [tadq_pkg::NODE_W-1:0]  req_parent_node,
   input  logic                         req_has_parent,
   input  logic [tadq_pkg::DEPTH_W-1:0] req_node_depth,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [tadq_pkg::NODE_W-1:0]  rsp_ancestor,
   input  logic [tadq_pkg::DIST_W-1:0]  rsp_distance,
   input  logic                         rsp_status,
   output int                           fail_count,
   output int                           results_owed
);

   localparam int NODE_W  = tadq_pkg::NODE_W;
   localparam int DEPTH_W = tadq_pkg::DEPTH_W;
   localparam int DIST_W  = tadq_pkg::DIST_W;

   tadq_pkg::entry_type  anc_tbl [0:LEVELS][0:NODES-1];
   logic [DEPTH_W-1:0]   depth_mem [0:NODES-1];
   tadq_pkg::result_type owed_q [$];
   int                   reported;

   function automatic void store_node(input int a, input int par, input logic hasp,
                                      input logic [DEPTH_W-1:0] dep);
      if (a < NODES) begin
         if (hasp && par < NODES) begin
            anc_tbl[0][a] = '{valid: 1'b1, node: NODE_W'(par)};
         end else begin
            anc_tbl[0][a] = tadq_pkg::ENTRY_NONE;
         end
         depth_mem[a] = dep;
      end
   endfunction

   function automatic void double_levels();
      int lv;
      int nd;
      tadq_pkg::entry_type mid;
      for (lv = 1; lv <= LEVELS; lv++) begin
         for (nd = 0; nd < NODES; nd++) begin
            mid = anc_tbl[lv-1][nd];
            if (mid.valid) begin
               anc_tbl[lv][nd] = anc_tbl[lv-1][int'(mid.node)];
            end else begin
               anc_tbl[lv][nd] = tadq_pkg::ENTRY_NONE;
            end
         end
      end
   endfunction

   function automatic tadq_pkg::result_type resolve_query(input int a, input int b);
      int hi;
      int lo;
      int gap;
      int x;
      int y;
      int lca;
      int lv;
      int span;
      tadq_pkg::entry_type e;
      tadq_pkg::entry_type px;
      tadq_pkg::entry_type py;
      if (a >= NODES || b >= NODES) return tadq_pkg::RES_FAIL;
      if (depth_mem[a] >= depth_mem[b]) begin
         hi = a;
         lo = b;
      end else begin
         hi = b;
         lo = a;
      end
      gap = int'(depth_mem[hi]) - int'(depth_mem[lo]);
      if ((gap >> (LEVELS + 1)) != 0) return tadq_pkg::RES_FAIL;
      for (lv = 0; lv <= LEVELS; lv++) begin
         if (((gap >> lv) & 1) != 0) begin
            e = anc_tbl[lv][hi];
            if (!e.valid) return tadq_pkg::RES_FAIL;
            hi = int'(e.node);
         end
      end
      x = hi;
      y = lo;
      if (x == y) begin
         lca = x;
      end else begin
         for (lv = LEVELS; lv >= 0; lv--) begin
            px = anc_tbl[lv][x];
            py = anc_tbl[lv][y];
            if (px.valid && py.valid && px != py) begin
               x = int'(px.node);
               y = int'(py.node);
            end
         end
         px = anc_tbl[0][x];
         py = anc_tbl[0][y];
         if (!px.valid || px != py) return tadq_pkg::RES_FAIL;
         lca = int'(px.node);
      end
      span = int'(depth_mem[a]) + int'(depth_mem[b]) - 2 * int'(depth_mem[lca]);
      if (span < 0) span = 0;
      if (span > 2047) span = 2047;
      return '{ancestor: NODE_W'(lca), distance: DIST_W'(span), status: 1'b0};
   endfunction

   function automatic tadq_pkg::result_type result_for_request(input logic [1:0] kind,
                                                               input int a, input int b,
                                                               input int par,
                                                               input logic hasp,
                                                               input logic [DEPTH_W-1:0] dep);
      tadq_pkg::result_type res;
      res = tadq_pkg::RES_ACK;
      case (kind)
         tadq_pkg::OP_LOAD: begin
            store_node(a, par, hasp, dep);
         end
         tadq_pkg::OP_BUILD: begin
            double_levels();
         end
         tadq_pkg::OP_QUERY: begin
            res = resolve_query(a, b);
         end
         default: begin
            res = tadq_pkg::RES_ACK;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      tadq_pkg::result_type want;
      int lv;
      int nd;
      if (reset) begin
         owed_q.delete();
         for (lv = 0; lv <= LEVELS; lv++) begin
            for (nd = 0; nd < NODES; nd++) begin
               anc_tbl[lv][nd] = tadq_pkg::ENTRY_NONE;
            end
         end
         for (nd = 0; nd < NODES; nd++) begin
            depth_mem[nd] = '0;
         end
         fail_count = 0;
         reported = 0;
      end else begin
         if (req_valid && req_ready) begin
            owed_q.insert(owed_q.size(),
                          result_for_request(req_type, int'(req_node_a), int'(req_node_b),
                                             int'(req_parent_node), req_has_parent,
                                             req_node_depth));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  $display("%0t: response with none outstanding: %0d %0d %0d",
                           $time, rsp_ancestor, rsp_distance, rsp_status);
                  reported++;
               end
            end else begin
               want = owed_q.pop_front();
               if (rsp_ancestor !== want.ancestor || rsp_distance !== want.distance ||
                   rsp_status !== want.status) begin
                  fail_count++;
                  if (reported < 10) begin
                     $display("%0t: expected %0d %0d %0d, actual %0d %0d %0d",
                              $time, want.ancestor, want.distance, want.status,
                              rsp_ancestor, rsp_distance, rsp_status);
                     reported++;
                  end
               end
            end
         end
      end
      results_owed = owed_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int         NODE_W      = tadq_pkg::NODE_W;
   localparam int         DEPTH_W     = tadq_pkg::DEPTH_W;
   localparam int         DIST_W      = tadq_pkg::DIST_W;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         NODE_COUNT  = 1024;
   localparam int         TOTAL_ITEMS = 1300;
   localparam int         STALL_LIMIT = 150000;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type        = '0;
   logic [NODE_W-1:0]  req_node_a      = '0;
   logic [NODE_W-1:0]  req_node_b      = '0;
   logic [NODE_W-1:0]  req_parent_node = '0;
   logic               req_has_parent  = 1'b0;
   logic [DEPTH_W-1:0] req_node_depth  = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [NODE_W-1:0]  rsp_ancestor;
   logic [DIST_W-1:0]  rsp_distance;
   logic               rsp_status;

   int fail_count;
   int results_owed;
   int stall_cycles   = 0;
   int send_idle_pct  = 13;
   int recv_idle_pct  = 47;
   int sent_items     = 0;

   int up_link [NODE_COUNT];
   int lvl [NODE_COUNT];
   int kids [NODE_COUNT];
   int order [NODE_COUNT];

   tree_ancestor_distance_query dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_node (req_parent_node),
      .req_has_parent  (req_has_parent),
      .req_node_depth  (req_node_depth),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_distance    (rsp_distance),
      .rsp_status      (rsp_status)
   );

   lca_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_node (req_parent_node),
      .req_has_parent  (req_has_parent),
      .req_node_depth  (req_node_depth),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_distance    (rsp_distance),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .results_owed    (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic drive_item(input logic [1:0] kind, input int a, input int b, input int par,
                             input logic hasp, input int dep);
      if (sent_items >= 2 * TOTAL_ITEMS / 3) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (sent_items >= TOTAL_ITEMS / 3) begin
         send_idle_pct = 47;
         recv_idle_pct = 13;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_type        = kind;
      req_node_a      = NODE_W'(a);
      req_node_b      = NODE_W'(b);
      req_parent_node = NODE_W'(par);
      req_has_parent  = hasp;
      req_node_depth  = DEPTH_W'(dep);
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic load_entry(input int v, input logic hasp, input int par, input int dep);
      if (up_link[v] >= 0) kids[up_link[v]]--;
      up_link[v] = hasp ? par : -1;
      if (hasp) kids[par]++;
      lvl[v] = dep;
      drive_item(tadq_pkg::OP_LOAD, v, $urandom_range(0, 1023),
                 hasp ? par : int'($urandom_range(0, 1023)), hasp, dep);
   endtask

   task automatic query_pair(input int a, input int b);
      drive_item(tadq_pkg::OP_QUERY, a, b, $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1023));
   endtask

   task automatic build_table();
      drive_item(tadq_pkg::OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
   endtask

   task automatic noise_load();
      load_entry($urandom_range(0, 1023), 1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
   endtask

   // A node without children can be moved anywhere without creating a cycle.
   task automatic move_leaf();
      int v;
      int p;
      int tries;
      v = $urandom_range(0, NODE_COUNT - 1);
      tries = 0;
      while (kids[v] != 0 && tries < 40) begin
         v = $urandom_range(0, NODE_COUNT - 1);
         tries++;
      end
      if (kids[v] == 0) begin
         p = $urandom_range(0, NODE_COUNT - 1);
         while (p == v || lvl[p] >= 1023) p = $urandom_range(0, NODE_COUNT - 1);
         if ($urandom_range(0, 7) == 0) begin
            load_entry(v, 1'b0, 0, 0);
         end else begin
            load_entry(v, 1'b1, p, lvl[p] + 1);
         end
      end
   endtask

   function automatic int climb(input int v, input int steps);
      int guard;
      guard = 0;
      while (steps > 0 && up_link[v] >= 0 && guard < 1100) begin
         v = up_link[v];
         steps--;
         guard++;
      end
      return v;
   endfunction

   initial begin
      int k;
      int j;
      int tmp;
      int p;
      int deep;
      int other_root;
      int q;
      int saved_up;
      int saved_lvl;
      int a;
      int pick;
      for (k = 0; k < NODE_COUNT; k++) begin
         up_link[k] = -1;
         lvl[k] = 0;
         kids[k] = 0;
         order[k] = k;
      end
      for (k = NODE_COUNT - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drive_item(OP_UNUSED, 0, 0, 0, 1'b0, 0);
      drive_item(OP_UNUSED, 1023, 1023, 1023, 1'b1, 1023);

      // One long chain first, then branches from random earlier nodes, with a few
      // extra roots so that the forest holds several trees.
      for (k = 0; k < NODE_COUNT; k++) begin
         if (k == 0 || k == 700 || (k >= 520 && $urandom_range(0, 63) == 0)) begin
            load_entry(order[k], 1'b0, 0, 0);
         end else begin
            if (k < 520 || $urandom_range(0, 1) == 0) p = order[k-1];
            else p = order[$urandom_range(0, k - 1)];
            if (lvl[p] >= 1023) load_entry(order[k], 1'b0, 0, 0);
            else load_entry(order[k], 1'b1, p, lvl[p] + 1);
         end
      end
      build_table();

      deep = order[0];
      for (k = 0; k < NODE_COUNT; k++) begin
         if (lvl[k] > lvl[deep]) deep = k;
      end
      other_root = order[700];
      q = order[1000];

      query_pair(order[0], order[0]);
      query_pair(deep, order[0]);
      query_pair(order[0], deep);
      query_pair(order[2], order[1]);
      query_pair(deep, other_root);
      query_pair(0, 1023);
      query_pair(1023, 1023);
      query_pair(deep, order[1023]);

      load_entry(q, 1'b0, 0, 1023);
      query_pair(q, order[0]);
      load_entry(q, 1'b1, order[0], 1);
      load_entry(order[0], 1'b0, 0, 1023);
      build_table();
      query_pair(q, order[1]);
      load_entry(order[0], 1'b0, 0, 0);

      saved_up = up_link[1023];
      saved_lvl = lvl[1023];
      load_entry(1023, 1'b1, 1023, 1023);
      build_table();
      query_pair(1023, order[0]);
      query_pair(1022, 1023);
      load_entry(1023, saved_up >= 0, saved_up >= 0 ? saved_up : 0, saved_lvl);

      while (sent_items < TOTAL_ITEMS) begin
         repeat ($urandom_range(0, 24)) begin
            if ($urandom_range(0, 9) == 0) noise_load();
            else move_leaf();
         end
         if ($urandom_range(0, 7) != 0) build_table();
         repeat ($urandom_range(60, 140)) begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, NODE_COUNT - 1);
            if (pick < 45) begin
               query_pair(a, $urandom_range(0, NODE_COUNT - 1));
            end else if (pick < 70) begin
               if ($urandom_range(0, 1) == 0) query_pair(a, climb(a, $urandom_range(0, lvl[a])));
               else query_pair(climb(a, $urandom_range(0, lvl[a])), a);
            end else if (pick < 80) begin
               query_pair(a, a);
            end else if (pick < 90) begin
               query_pair(climb(a, $urandom_range(0, 3)),
                          climb($urandom_range(0, NODE_COUNT - 1), $urandom_range(0, 3)));
            end else if (pick < 93) begin
               drive_item(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 1023));
            end else if (pick < 97) begin
               noise_load();
            end else begin
               move_leaf();
            end
         end
      end
      req_valid = 1'b0;

      while (results_owed != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tadq_pkg.sv
hw/rtl/tadq_ram.sv
hw/rtl/tadq_ctrl.sv
hw/rtl/tree_ancestor_distance_query.sv
tb/sv/lca_checker.sv
tb/sv/tb.sv
